[hw/rtl/lrd_pkg.sv]
package lrd_pkg;

    // Header and record geometry.
    localparam int HEADER_BYTES = 32;
    localparam int FIXED_BYTES  = 8 + 8 + 1 + 8 + 4;
    localparam int CRC_BYTES    = 4;

    // Reflected CRC-32.
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    // Register reset values.
    localparam logic [15:0] VERSION_RESET  = 16'd1;
    localparam logic [31:0] PAGESIZE_RESET = 32'd4096;

    // Register index, taken from paddr[2].
    localparam logic REG_VERSION  = 1'b0;
    localparam logic REG_PAGESIZE = 1'b1;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FIXED,
        PH_PAYLOAD,
        PH_CRC
    } phase_t;

    // Result kinds.
    localparam logic [1:0] KIND_FIELDS  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Verdict codes.
    localparam logic [2:0] VERDICT_GOOD = 3'd0;
    localparam logic [2:0] VERDICT_BAD  = 3'd1;

    // Stream end codes.
    localparam logic [2:0] END_CLEAN     = 3'd0;
    localparam logic [2:0] END_TRUNCATED = 3'd1;
    localparam logic [2:0] END_CRC       = 3'd2;
    localparam logic [2:0] END_SHORT     = 3'd3;
    localparam logic [2:0] END_MAGIC     = 3'd4;
    localparam logic [2:0] END_VERSION   = 3'd5;
    localparam logic [2:0] END_PAGESIZE  = 3'd6;
    localparam logic [2:0] FAULT_NONE    = 3'd0;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [7:0]  payload_byte;
        logic [31:0] payload_length;
        logic [63:0] page_number;
        logic [7:0]  record_type;
        logic [63:0] transaction_id;
        logic [63:0] sequence_number;
    } result_t;

    // One byte of CRC update, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // Magic bytes at the start of the header.
    function automatic logic [7:0] magic_byte(input logic [1:0] i);
        logic [7:0] m;
        unique case (i)
            2'd0: m = 8'h4D;
            2'd1: m = 8'h4F;
            2'd2: m = 8'h57;
            2'd3: m = 8'h4C;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/log_record_deframer_crc32.sv]
// Latency: a byte's results are registered at the edge that accepts the byte and are
// offered on the m_ side in the next cycle if no older result is queued ahead of them.
// Throughput: one byte per cycle while the queue has room for two results; a byte
// with two results needs two output transfers on the single port of the 4-entry queue.
// Reset: synchronous, active low; clears the parser, the queue and sets the registers
// to version 1 and page size 4096. No clearing pass is needed.
module log_record_deframer_crc32 (
    input  logic         aclk,
    input  logic         aresetn,
    // Input byte stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last byte of the file
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [63:0] sequence_number, [127:64] transaction_id, [135:128] record_type,
    // [199:136] page_number, [231:200] payload_length, [239:232] payload_byte,
    // [242:240] status, [247:243] zero
    output logic [247:0] m_tdata,
    output logic [1:0]   m_tuser,   // [1:0] kind
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import lrd_pkg::*;

    // Configuration registers.
    logic [15:0] exp_version_reg;
    logic [31:0] exp_pagesize_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [2:0]  fault_reg, fault_next;
    logic        halted_reg, halted_next;
    logic [63:0] seq_reg, seq_next;
    logic [63:0] txn_reg, txn_next;
    logic [63:0] page_reg, page_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] crcst_reg, crcst_next;
    logic [15:0] ver_reg, ver_next;
    logic [31:0] psz_reg, psz_next;

    // Result queue: four entries, up to two pushed per accepted byte.
    result_t     queue_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  fill_reg;

    logic        s_fire, m_fire, work;
    logic [7:0]  b;
    logic        last;
    logic [31:0] cnt_inc;
    logic        hdr_last, fixed_last, crc_last, pay_last;
    logic [31:0] crc_upd, len_new, crcst_new;
    logic        crc_good;
    result_t     res0, res1;
    logic [1:0]  n_res;
    logic        end_flag;
    logic [2:0]  end_status;
    result_t     head;

    assign b      = s_tdata;
    assign last   = s_tlast;
    assign s_fire = s_tvalid & s_tready;
    assign m_fire = m_tvalid & m_tready;
    assign work   = s_fire & ~halted_reg;

    // Room for two results is needed before a byte is taken.
    assign s_tready = (fill_reg <= 3'd2);
    assign m_tvalid = (fill_reg != 3'd0);

    assign cnt_inc    = count_reg + 32'd1;
    assign hdr_last   = (count_reg >= 32'(HEADER_BYTES - 1));
    assign fixed_last = (count_reg >= 32'(FIXED_BYTES - 1));
    assign crc_last   = (count_reg >= 32'(CRC_BYTES - 1));
    assign pay_last   = (cnt_inc == len_reg);
    assign crc_upd    = crc_byte(crc_reg, b);
    assign len_new    = {b, len_reg[31:8]};
    assign crcst_new  = {b, crcst_reg[31:8]};
    assign crc_good   = ((crc_reg ^ CRC_ONES) == crcst_new);

    // Header checks. Only the first fault is kept.
    always_comb begin
        fault_next = fault_reg;
        ver_next   = ver_reg;
        psz_next   = psz_reg;
        if (phase_reg == PH_HEADER) begin
            if (count_reg < 32'd4 && b != magic_byte(count_reg[1:0])
                    && fault_reg == FAULT_NONE) begin
                fault_next = END_MAGIC;
            end
            if (count_reg == 32'd4 || count_reg == 32'd5) begin
                ver_next = {b, ver_reg[15:8]};
            end
            if (count_reg == 32'd5 && fault_next == FAULT_NONE
                    && ver_next != exp_version_reg) begin
                fault_next = END_VERSION;
            end
            if (count_reg >= 32'd8 && count_reg <= 32'd11) begin
                psz_next = {b, psz_reg[31:8]};
            end
            if (count_reg == 32'd11 && fault_next == FAULT_NONE
                    && psz_next != exp_pagesize_reg) begin
                fault_next = END_PAGESIZE;
            end
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER: begin
                if (hdr_last && fault_next == FAULT_NONE && !last) begin
                    phase_next = PH_FIXED;
                end
            end
            PH_FIXED: begin
                if (fixed_last) begin
                    phase_next = (len_new != 32'd0) ? PH_PAYLOAD : PH_CRC;
                end
            end
            PH_PAYLOAD: begin
                if (pay_last) begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                if (crc_last && crc_good && !last) begin
                    phase_next = PH_FIXED;
                end
            end
            default: phase_next = phase_reg;
        endcase
    end

    // Field capture, CRC and results.
    always_comb begin
        seq_next   = seq_reg;
        txn_next   = txn_reg;
        page_next  = page_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        crcst_next = crcst_reg;
        crc_next   = crc_reg;
        res0       = '0;
        res1       = '0;
        n_res      = 2'd0;
        end_flag   = 1'b0;
        end_status = END_CLEAN;

        unique case (phase_reg)
            PH_HEADER: begin
                if (hdr_last) begin
                    if (fault_next != FAULT_NONE) begin
                        end_flag   = 1'b1;
                        end_status = fault_next;
                    end else if (last) begin
                        end_flag   = 1'b1;
                        end_status = END_CLEAN;
                    end
                end else if (last) begin
                    end_flag   = 1'b1;
                    end_status = END_SHORT;
                end
            end
            PH_FIXED: begin
                crc_next = crc_upd;
                if (count_reg < 32'd8) begin
                    seq_next = {b, seq_reg[63:8]};
                end else if (count_reg < 32'd16) begin
                    txn_next = {b, txn_reg[63:8]};
                end else if (count_reg == 32'd16) begin
                    type_next = b;
                end else if (count_reg < 32'd25) begin
                    page_next = {b, page_reg[63:8]};
                end else begin
                    len_next = len_new;
                end
                if (fixed_last) begin
                    res0.kind            = KIND_FIELDS;
                    res0.sequence_number = seq_reg;
                    res0.transaction_id  = txn_reg;
                    res0.record_type     = type_reg;
                    res0.page_number     = page_reg;
                    res0.payload_length  = len_new;
                    n_res                = 2'd1;
                end
                if (last) begin
                    end_flag   = 1'b1;
                    end_status = END_TRUNCATED;
                end
            end
            PH_PAYLOAD: begin
                crc_next          = crc_upd;
                res0.kind         = KIND_PAYLOAD;
                res0.payload_byte = b;
                n_res             = 2'd1;
                if (last) begin
                    end_flag   = 1'b1;
                    end_status = END_TRUNCATED;
                end
            end
            PH_CRC: begin
                crcst_next = crcst_new;
                if (crc_last) begin
                    res0.kind   = KIND_VERDICT;
                    res0.status = crc_good ? VERDICT_GOOD : VERDICT_BAD;
                    n_res       = 2'd1;
                    if (!crc_good) begin
                        end_flag   = 1'b1;
                        end_status = END_CRC;
                    end else if (last) begin
                        end_flag   = 1'b1;
                        end_status = END_CLEAN;
                    end
                end else if (last) begin
                    end_flag   = 1'b1;
                    end_status = END_TRUNCATED;
                end
            end
            default: n_res = 2'd0;
        endcase

        // A new record starts with a fresh CRC.
        if (phase_next == PH_FIXED && phase_reg != PH_FIXED) begin
            crc_next = CRC_ONES;
        end

        // The stream end always follows whatever the byte itself produced.
        if (end_flag) begin
            if (n_res == 2'd0) begin
                res0.kind   = KIND_END;
                res0.status = end_status;
            end else begin
                res1.kind   = KIND_END;
                res1.status = end_status;
            end
            n_res = n_res + 2'd1;
        end
    end

    // Counter restarts whenever the phase moves on.
    assign count_next  = (phase_next != phase_reg) ? 32'd0 : cnt_inc;
    assign halted_next = halted_reg | (work & end_flag);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            count_reg  <= 32'd0;
            fault_reg  <= FAULT_NONE;
            halted_reg <= 1'b0;
        end else begin
            halted_reg <= halted_next;
            if (work) begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                fault_reg <= fault_next;
            end
        end
    end

    // Captured fields and CRC; every value is fully rewritten before it is used.
    always_ff @(posedge aclk) begin
        if (work) begin
            seq_reg   <= seq_next;
            txn_reg   <= txn_next;
            page_reg  <= page_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            crcst_reg <= crcst_next;
            ver_reg   <= ver_next;
            psz_reg   <= psz_next;
        end
    end

    // Result queue pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            fill_reg   <= 3'd0;
        end else begin
            if (work) begin
                wr_ptr_reg <= wr_ptr_reg + n_res;
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            fill_reg <= fill_reg + (work ? {1'b0, n_res} : 3'd0) - {2'd0, m_fire};
        end
    end

    // Result queue storage.
    always_ff @(posedge aclk) begin
        if (work) begin
            if (n_res != 2'd0) begin
                queue_reg[wr_ptr_reg] <= res0;
            end
            if (n_res == 2'd2) begin
                queue_reg[wr_ptr_reg + 2'd1] <= res1;
            end
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tuser = head.kind;
    assign m_tdata = {5'd0, head.status, head.payload_byte, head.payload_length,
                      head.page_number, head.record_type, head.transaction_id,
                      head.sequence_number};

    // Configuration registers: version at byte address 0, page size at 4.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_version_reg  <= VERSION_RESET;
            exp_pagesize_reg <= PAGESIZE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_VERSION) begin
                exp_version_reg <= pwdata[15:0];
            end else begin
                exp_pagesize_reg <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == REG_PAGESIZE) ? exp_pagesize_reg
                                               : {16'd0, exp_version_reg};

endmodule

[tb/sv/log_record_deframer_crc32_tb.sv]
`timescale 1ns / 100ps

module log_record_deframer_crc32_tb;
    import lrd_pkg::*;

    // A block reset only once can report only one stream end per run. The run therefore
    // picks at random how the log ends: in the header (short file, bad magic, bad
    // version, bad page size, empty log) or after many records (clean, truncated tail,
    // CRC mismatch). The seed decides which, so the endings are spread over seeds.
    typedef enum logic [2:0] {
        ENDING_CLEAN,
        ENDING_TRUNCATED,
        ENDING_BAD_CRC,
        ENDING_SHORT,
        ENDING_MAGIC,
        ENDING_VERSION,
        ENDING_PAGESIZE,
        ENDING_EMPTY
    } ending_t;

    // How the payload bytes of a record are made up.
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_CONST,
        FILL_COUNT
    } fill_t;

    // One log record as the stimulus side sees it.
    typedef struct {
        logic [63:0] seq;
        logic [63:0] txn;
        logic [7:0]  rtype;
        logic [63:0] page;
        logic [31:0] len;
        fill_t       fill_mode;
        logic [7:0]  fill_byte;
        logic        pin_good;   // the verdict is typed in as good, not predicted
    } log_rec_t;

    // The four magic bytes, first byte in the lowest bits.
    localparam logic [31:0] HEADER_MAGIC = 32'h4C57_4F4D;
    localparam int RANDOM_BYTES = 100;

    // Clock, reset and the block's ports. Every input has a known value from time zero.
    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'd0;
    logic         s_tlast  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [247:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = 3'd0;
    logic [31:0]  pwdata   = 32'd0;
    logic [31:0]  prdata;
    logic         pready;

    always #5 aclk = ~aclk;

    log_record_deframer_crc32 uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Results the parser must still deliver, oldest first.
    result_t log_items_q[$];
    int      error_count = 0;
    int      bytes_sent  = 0;

    // Copy of the two registers as the block should hold them.
    logic [15:0] cfg_version   = 16'd1;
    logic [31:0] cfg_page_size = 32'd4096;

    // Parser state of the predictor.
    phase_t      parse_phase = PH_HEADER;
    logic [31:0] parse_pos   = 32'd0;
    logic [2:0]  hdr_fault   = FAULT_NONE;
    logic [63:0] seq_acc     = 64'd0;
    logic [63:0] txn_acc     = 64'd0;
    logic [63:0] page_acc    = 64'd0;
    logic [7:0]  type_acc    = 8'd0;
    logic [31:0] len_acc     = 32'd0;
    logic [31:0] crc_acc     = CRC_ONES;
    logic [31:0] crc_rx      = 32'd0;
    logic [15:0] ver_acc     = 16'd0;
    logic [31:0] psize_acc   = 32'd0;
    logic        log_closed  = 1'b0;

    // Idling controls for both sides.
    logic src_burst       = 1'b0;
    int   stall_left      = 0;
    int   sink_burst_left = 0;

    // Every mismatch goes through here: one line each, and the count.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Reflected CRC-32, one data bit per step, least significant bit first.
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Appends one owed result behind the others.
    task automatic owe_result(input result_t r);
        log_items_q = {log_items_q, r};
    endtask

    task automatic close_log(input logic [2:0] code);
        result_t r;
        r = '0;
        r.kind = KIND_END;
        r.status = code;
        owe_result(r);
        log_closed = 1'b1;
    endtask

    task automatic open_record();
        parse_phase = PH_FIXED;
        parse_pos = 32'd0;
        crc_acc = CRC_ONES;
    endtask

    // Predictor: works out what one accepted byte of the file must produce and queues it.
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        result_t r;
        logic    crc_ok;
        if (log_closed) begin
            return;
        end
        r = '0;
        case (parse_phase)
            PH_HEADER: begin
                // Faults are latched in order of position, so the first one wins.
                if (parse_pos < 4 && b != HEADER_MAGIC[8*parse_pos[1:0] +: 8]
                        && hdr_fault == FAULT_NONE) begin
                    hdr_fault = END_MAGIC;
                end
                if (parse_pos == 4 || parse_pos == 5) begin
                    ver_acc = {b, ver_acc[15:8]};
                end
                if (parse_pos == 5 && hdr_fault == FAULT_NONE && ver_acc != cfg_version) begin
                    hdr_fault = END_VERSION;
                end
                if (parse_pos >= 8 && parse_pos <= 11) begin
                    psize_acc = {b, psize_acc[31:8]};
                end
                if (parse_pos == 11 && hdr_fault == FAULT_NONE
                        && psize_acc != cfg_page_size) begin
                    hdr_fault = END_PAGESIZE;
                end
                parse_pos++;
                if (parse_pos >= HEADER_BYTES) begin
                    if (hdr_fault != FAULT_NONE) begin
                        close_log(hdr_fault);
                    end else if (last) begin
                        close_log(END_CLEAN);
                    end else begin
                        open_record();
                    end
                end else if (last) begin
                    close_log(END_SHORT);
                end
            end
            PH_FIXED: begin
                crc_acc = crc32_step(crc_acc, b);
                if (parse_pos < 8) begin
                    seq_acc = {b, seq_acc[63:8]};
                end else if (parse_pos < 16) begin
                    txn_acc = {b, txn_acc[63:8]};
                end else if (parse_pos == 16) begin
                    type_acc = b;
                end else if (parse_pos < 25) begin
                    page_acc = {b, page_acc[63:8]};
                end else begin
                    len_acc = {b, len_acc[31:8]};
                end
                parse_pos++;
                if (parse_pos >= FIXED_BYTES) begin
                    r.kind = KIND_FIELDS;
                    r.sequence_number = seq_acc;
                    r.transaction_id = txn_acc;
                    r.record_type = type_acc;
                    r.page_number = page_acc;
                    r.payload_length = len_acc;
                    owe_result(r);
                    parse_pos = 32'd0;
                    parse_phase = (len_acc != 32'd0) ? PH_PAYLOAD : PH_CRC;
                end
                if (last) begin
                    close_log(END_TRUNCATED);
                end
            end
            PH_PAYLOAD: begin
                crc_acc = crc32_step(crc_acc, b);
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                owe_result(r);
                parse_pos++;
                if (parse_pos >= len_acc) begin
                    parse_pos = 32'd0;
                    parse_phase = PH_CRC;
                end
                if (last) begin
                    close_log(END_TRUNCATED);
                end
            end
            default: begin
                crc_rx = {b, crc_rx[31:8]};
                parse_pos++;
                if (parse_pos >= CRC_BYTES) begin
                    crc_ok = ((crc_acc ^ CRC_ONES) == crc_rx);
                    r.kind = KIND_VERDICT;
                    r.status = crc_ok ? VERDICT_GOOD : VERDICT_BAD;
                    owe_result(r);
                    if (!crc_ok) begin
                        close_log(END_CRC);
                    end else if (last) begin
                        close_log(END_CLEAN);
                    end else begin
                        open_record();
                    end
                end else if (last) begin
                    close_log(END_TRUNCATED);
                end
            end
        endcase
    endtask

    // Replaces the newest result of a kind, among the two newest queued, by a hand-typed
    // value. Only verdicts and stream ends are typed this way; their other fields are zero.
    task automatic pin_result(input logic [1:0] kind, input logic [2:0] code);
        result_t r;
        r = '0;
        r.kind = kind;
        r.status = code;
        for (int i = log_items_q.size() - 1; i >= 0 && i >= log_items_q.size() - 2; i--) begin
            if (log_items_q[i].kind == kind) begin
                log_items_q[i] = r;
                return;
            end
        end
        report_mismatch("typed result not produced, kind", 64'(kind), 64'(code));
    endtask

    // Source gaps: mostly none or short, a few long, none at all in a burst.
    function automatic int pick_gap();
        int r;
        if (src_burst) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offers one byte at a falling edge and waits for its transfer. Valid stays high
    // after the transfer, so back-to-back bytes never drop it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        deframe_byte(b, last);
    endtask

    task automatic source_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
    endtask

    // Waits until every queued result has been taken, then for the output latency.
    task automatic drain_results();
        while (log_items_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr[2] == REG_VERSION) begin
            cfg_version = data[15:0];
        end else begin
            cfg_page_size = data;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_registers();
        logic [31:0] v;
        apb_read({REG_VERSION, 2'b00}, v);
        if (v !== {16'd0, cfg_version}) begin
            report_mismatch("expected_version readback", 64'(v), 64'(cfg_version));
        end
        apb_read({REG_PAGESIZE, 2'b00}, v);
        if (v !== cfg_page_size) begin
            report_mismatch("expected_page_size readback", 64'(v), 64'(cfg_page_size));
        end
    endtask

    function automatic logic [15:0] pick_version();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return VERSION_RESET;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_page_size();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return PAGESIZE_RESET;
            default: return $urandom;
        endcase
    endfunction

    // New register values in the middle of the log. The header check is long past, so
    // the parsing must not change; the writes and readbacks are what is checked here.
    task automatic retune_registers();
        source_idle();
        drain_results();
        apb_write({REG_PAGESIZE, 2'b00}, pick_page_size());
        apb_write({REG_VERSION, 2'b00}, {16'd0, pick_version()});
        verify_registers();
    endtask

    function automatic log_rec_t random_record();
        log_rec_t r;
        int pick;
        r.seq = {$urandom, $urandom};
        r.txn = {$urandom, $urandom};
        r.page = {$urandom, $urandom};
        r.rtype = 8'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            r.len = $urandom_range(0, 6);
        end else if (pick < 19) begin
            r.len = $urandom_range(7, 24);
        end else begin
            r.len = $urandom_range(25, 64);
        end
        r.fill_mode = FILL_RANDOM;
        r.fill_byte = 8'd0;
        r.pin_good = 1'b0;
        return r;
    endfunction

    // Sends one record: fixed part, payload and the stored CRC. With bad_crc one bit of
    // the stored CRC is flipped. stop_at is the byte that carries tlast (-1 for none);
    // the record is cut off right after it.
    task automatic send_record(input log_rec_t rec, input logic bad_crc,
                               input longint stop_at);
        logic [8*FIXED_BYTES-1:0] fixed_part;
        logic [31:0] crc;
        logic [31:0] stored;
        logic [7:0]  b;
        longint      body;
        longint      total;
        src_burst = ($urandom_range(0, 4) == 0);
        fixed_part = {rec.len, rec.page, rec.rtype, rec.txn, rec.seq};
        body = FIXED_BYTES + longint'(rec.len);
        total = body + CRC_BYTES;
        crc = CRC_ONES;
        stored = 32'd0;
        for (longint k = 0; k < total; k++) begin
            if (k < FIXED_BYTES) begin
                b = fixed_part[8*k +: 8];
            end else if (k < body) begin
                case (rec.fill_mode)
                    FILL_CONST: b = rec.fill_byte;
                    FILL_COUNT: b = rec.fill_byte + 8'(k - FIXED_BYTES);
                    default:    b = 8'($urandom);
                endcase
            end else begin
                if (k == body) begin
                    stored = ~crc ^ (bad_crc ? (32'd1 << $urandom_range(0, 31)) : 32'd0);
                end
                b = stored[8*(k - body) +: 8];
            end
            if (k < body) begin
                crc = crc32_step(crc, b);
            end
            send_byte(b, k == stop_at);
            if (k == stop_at) begin
                break;
            end
        end
        if (rec.pin_good) begin
            pin_result(KIND_VERDICT, VERDICT_GOOD);
        end
    endtask

    // Sends the 32-byte file header built from the current register values, spoiled or
    // cut short as the chosen ending asks. Header endings have their code typed in.
    task automatic send_header(input ending_t ending);
        logic [8*HEADER_BYTES-1:0] hdr;
        logic [31:0] flip;
        int cut;
        for (int w = 0; w < HEADER_BYTES / 4; w++) begin
            hdr[32*w +: 32] = $urandom;
        end
        hdr[31:0] = HEADER_MAGIC;
        hdr[47:32] = cfg_version;
        hdr[95:64] = cfg_page_size;
        cut = -1;
        flip = $urandom;
        if (flip == 32'd0) begin
            flip = 32'd1;
        end
        // Later faults are sometimes added too: only the first one may be reported.
        case (ending)
            ENDING_MAGIC: begin
                hdr[8*$urandom_range(0, 3) +: 8] ^= 8'($urandom_range(1, 255));
                if ($urandom_range(0, 1)) hdr[47:32] ^= 16'($urandom_range(1, 65535));
                if ($urandom_range(0, 1)) hdr[95:64] ^= flip;
            end
            ENDING_VERSION: begin
                hdr[47:32] ^= 16'($urandom_range(1, 65535));
                if ($urandom_range(0, 1)) hdr[95:64] ^= flip;
            end
            ENDING_PAGESIZE: begin
                hdr[95:64] ^= flip;
            end
            ENDING_SHORT: begin
                cut = $urandom_range(0, HEADER_BYTES - 2);
                if ($urandom_range(0, 1)) hdr[8*$urandom_range(0, 11) +: 8] ^= 8'hA5;
            end
            ENDING_EMPTY: begin
                cut = HEADER_BYTES - 1;
            end
            default: begin
            end
        endcase
        for (int k = 0; k < HEADER_BYTES; k++) begin
            send_byte(hdr[8*k +: 8], k == cut);
            if (k == cut) begin
                break;
            end
        end
        case (ending)
            ENDING_SHORT:    pin_result(KIND_END, END_SHORT);
            ENDING_MAGIC:    pin_result(KIND_END, END_MAGIC);
            ENDING_VERSION:  pin_result(KIND_END, END_VERSION);
            ENDING_PAGESIZE: pin_result(KIND_END, END_PAGESIZE);
            ENDING_EMPTY:    pin_result(KIND_END, END_CLEAN);
            default: begin
            end
        endcase
    endtask

    // Bytes after the stream end must be swallowed without any result.
    task automatic send_ignored(input int count);
        for (int i = 0; i < count; i++) begin
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    // Directed records: all-zero and all-one fields, alternating bit patterns, empty,
    // one-byte and longer payloads. The first three have a verdict of good typed in.
    log_rec_t directed_recs [6] = '{
        '{64'h0, 64'h0, 8'h00, 64'h0, 32'd0, FILL_RANDOM, 8'h00, 1'b1},
        '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
          64'hFFFF_FFFF_FFFF_FFFF, 32'd1, FILL_CONST, 8'hFF, 1'b1},
        '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55,
          64'hAAAA_AAAA_AAAA_AAAA, 32'd2, FILL_CONST, 8'h00, 1'b1},
        '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 8'h80,
          64'h8000_0000_0000_0001, 32'd5, FILL_COUNT, 8'hFB, 1'b0},
        '{64'h1, 64'h2, 8'h7F, 64'h3, 32'd40, FILL_COUNT, 8'h00, 1'b0},
        '{64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 8'h01,
          64'h00FF_00FF_00FF_00FF, 32'd3, FILL_RANDOM, 8'h00, 1'b0}
    };

    // Result side: random stalls, mostly short with a few long ones, and stretches in
    // which every transfer is taken at once. m_tready changes at falling edges only.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (sink_burst_left > 0) begin
            sink_burst_left <= sink_burst_left - 1;
            m_tready <= 1'b1;
        end else begin
            case ($urandom_range(0, 99)) inside
                [0:4]: begin
                    sink_burst_left <= $urandom_range(20, 80);
                    m_tready <= 1'b1;
                end
                [5:24]: begin
                    stall_left <= $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end
                [25:26]: begin
                    stall_left <= $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // Every result transfer is unpacked and compared, field by field, with the oldest
    // result still owed.
    result_t got_item;
    result_t want_item;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_item.sequence_number = m_tdata[63:0];
            got_item.transaction_id  = m_tdata[127:64];
            got_item.record_type     = m_tdata[135:128];
            got_item.page_number     = m_tdata[199:136];
            got_item.payload_length  = m_tdata[231:200];
            got_item.payload_byte    = m_tdata[239:232];
            got_item.status          = m_tdata[242:240];
            got_item.kind            = m_tuser;
            if (log_items_q.size() == 0) begin
                report_mismatch("result with none owed, kind", 64'(got_item.kind), '0);
            end else begin
                want_item = log_items_q.pop_front();
                if (got_item.kind !== want_item.kind)
                    report_mismatch("kind", 64'(got_item.kind), 64'(want_item.kind));
                if (got_item.sequence_number !== want_item.sequence_number)
                    report_mismatch("sequence_number", got_item.sequence_number,
                                    want_item.sequence_number);
                if (got_item.transaction_id !== want_item.transaction_id)
                    report_mismatch("transaction_id", got_item.transaction_id,
                                    want_item.transaction_id);
                if (got_item.record_type !== want_item.record_type)
                    report_mismatch("record_type", 64'(got_item.record_type),
                                    64'(want_item.record_type));
                if (got_item.page_number !== want_item.page_number)
                    report_mismatch("page_number", got_item.page_number,
                                    want_item.page_number);
                if (got_item.payload_length !== want_item.payload_length)
                    report_mismatch("payload_length", 64'(got_item.payload_length),
                                    64'(want_item.payload_length));
                if (got_item.payload_byte !== want_item.payload_byte)
                    report_mismatch("payload_byte", 64'(got_item.payload_byte),
                                    64'(want_item.payload_byte));
                if (got_item.status !== want_item.status)
                    report_mismatch("status", 64'(got_item.status), 64'(want_item.status));
            end
        end
    end

    // Main sequence: registers, header, directed records, random records, the ending.
    initial begin : main_flow
        ending_t  ending;
        log_rec_t rec;
        int       pick;
        int       random_start;
        longint   cut;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values first, then both extremes, then the values the header carries.
        verify_registers();
        apb_write({REG_VERSION, 2'b00}, 32'h0000_FFFF);
        apb_write({REG_PAGESIZE, 2'b00}, 32'hFFFF_FFFF);
        verify_registers();
        apb_write({REG_PAGESIZE, 2'b00}, 32'h0000_0000);
        apb_write({REG_VERSION, 2'b00}, 32'h0000_0000);
        verify_registers();
        apb_write({REG_VERSION, 2'b00}, {16'd0, pick_version()});
        apb_write({REG_PAGESIZE, 2'b00}, pick_page_size());
        verify_registers();

        pick = $urandom_range(0, 15);
        if (pick < 4) begin
            ending = ending_t'(ENDING_SHORT + $urandom_range(0, 4));
        end else begin
            ending = ending_t'((pick - 4) / 4);
        end

        send_header(ending);

        if (ending >= ENDING_SHORT) begin
            // The log ended in its header; the rest of the file must be ignored.
            send_ignored(420);
        end else begin
            foreach (directed_recs[i]) begin
                send_record(directed_recs[i], 1'b0, -1);
            end

            random_start = bytes_sent;
            while (bytes_sent - random_start < RANDOM_BYTES) begin
                send_record(random_record(), 1'b0, -1);
                if ($urandom_range(0, 3) == 0) begin
                    retune_registers();
                end
            end

            rec = random_record();
            case (ending)
                ENDING_CLEAN: begin
                    send_record(rec, 1'b0, FIXED_BYTES + longint'(rec.len) + CRC_BYTES - 1);
                    pin_result(KIND_END, END_CLEAN);
                end
                ENDING_BAD_CRC: begin
                    // tlast either on the final CRC byte or, at random, among the ignored bytes.
                    cut = $urandom_range(0, 1) ?
                          FIXED_BYTES + longint'(rec.len) + CRC_BYTES - 1 : -1;
                    send_record(rec, 1'b1, cut);
                    pin_result(KIND_VERDICT, VERDICT_BAD);
                    pin_result(KIND_END, END_CRC);
                end
                default: begin
                    // Truncated tail: sometimes behind a huge payload length, cut in
                    // the fixed part, the payload or the stored CRC.
                    case ($urandom_range(0, 3))
                        0: rec.len = 32'hFFFF_FFFF;
                        1: rec.len = $urandom;
                        default: begin
                        end
                    endcase
                    cut = longint'($urandom_range(0, FIXED_BYTES + CRC_BYTES - 2
                                   + ((rec.len < 16) ? rec.len : 16)));
                    send_record(rec, 1'b0, cut);
                    pin_result(KIND_END, END_TRUNCATED);
                end
            endcase
            send_ignored($urandom_range(4, 16));
        end

        source_idle();
        drain_results();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS log_record_deframer_crc32");
        end else begin
            $display("FAIL log_record_deframer_crc32");
        end
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("FAIL log_record_deframer_crc32");
        $finish;
    end

endmodule
